// ===== rtl/apt_pkg.sv =====
// Shared constants, codes and types for the affine point transform.
`default_nettype none
package apt_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_WIDTH = 32;
  localparam int CW          = COORD_WIDTH;
  localparam int NUM_REGS    = 6;
  localparam int IDX_W       = 3;
  localparam int CFG_W       = 64;
  localparam int IO_W        = 32;

  // divider numerator width (|p| << FRAC_BITS)
  localparam int NW  = CW + FRAC_BITS;
  // product and sum-of-three widths
  localparam int PW  = 2 * CW;
  localparam int SW  = PW + 2;
  localparam int RW  = SW - FRAC_BITS;
  // common signed width ahead of saturation
  localparam int VW  = (RW > NW + 1) ? RW : NW + 1;
  // lane: operand, product, sum, one stage per quotient bit, output
  localparam int LAT = NW + 4;

  localparam logic [2:0] CMD_ROT  = 3'd0;
  localparam logic [2:0] CMD_IROT = 3'd1;
  localparam logic [2:0] CMD_TRN  = 3'd2;
  localparam logic [2:0] CMD_ITRN = 3'd3;
  localparam logic [2:0] CMD_SCL  = 3'd4;
  localparam logic [2:0] CMD_ISCL = 3'd5;

  localparam logic [IDX_W-1:0] REG_E0_E1   = 3'd0;
  localparam logic [IDX_W-1:0] REG_E2_E4   = 3'd1;
  localparam logic [IDX_W-1:0] REG_E5_E6   = 3'd2;
  localparam logic [IDX_W-1:0] REG_E8_E9   = 3'd3;
  localparam logic [IDX_W-1:0] REG_E10_E12 = 3'd4;
  localparam logic [IDX_W-1:0] REG_E13_E14 = 3'd5;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct packed {
    coord_t q;
    logic   ovf;
    logic   dz;
  } lane_res_t;

endpackage
`default_nettype wire

// ===== rtl/apt_lane.sv =====
// One coordinate lane: dot product, translate, scale and pipelined divide.
`default_nettype none
module apt_lane import apt_pkg::*; (
  input  wire logic      clk,
  input  wire logic      en,
  input  wire logic [2:0] cmd,
  input  wire coord_t    u [3],
  input  wire coord_t    k [3],
  input  wire coord_t    p,
  input  wire coord_t    t,
  input  wire coord_t    d,
  output lane_res_t      res
);

  function automatic logic [CW:0] sat_fn(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] mx;
    logic signed [VW-1:0] mn;
    mx = {{(VW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    mn = ~mx;
    if (v > mx) return {1'b1, mx[CW-1:0]};
    if (v < mn) return {1'b1, mn[CW-1:0]};
    return {1'b0, v[CW-1:0]};
  endfunction

  // stage 1: operands
  logic [2:0] cmd1_r;
  coord_t     u1_r [3];
  coord_t     k1_r [3];
  coord_t     p1_r, t1_r, d1_r;

  // stage 2: products
  logic [2:0]          cmd2_r;
  logic signed [PW-1:0] prod2_r [3];
  coord_t              p2_r, t2_r, d2_r;

  // stage 3 onwards: divider array with carried metadata
  logic [2:0]           cmd_r  [NW+1];
  logic signed [VW-1:0] val_r  [NW+1];
  logic                 qneg_r [NW+1];
  logic                 dz_r   [NW+1];
  logic                 ppos_r [NW+1];
  logic                 pneg_r [NW+1];
  logic [CW-1:0]        dm_r   [NW+1];
  logic [CW-1:0]        rem_r  [NW+1];
  logic [NW-1:0]        qn_r   [NW+1];

  lane_res_t res_r;

  logic signed [SW-1:0] sum;
  logic signed [VW-1:0] val_nxt;
  logic [CW-1:0]        pmag, dmag;
  logic [CW:0]          sh   [NW];
  logic                 ge   [NW];
  logic [CW-1:0]        nrem [NW];
  logic signed [VW-1:0] qs;
  logic [CW:0]          sat_v;
  lane_res_t            res_nxt;

  always_comb begin
    sum = SW'(prod2_r[0]) + SW'(prod2_r[1]) + SW'(prod2_r[2]);
    case (cmd2_r)
      CMD_ROT, CMD_IROT, CMD_SCL: val_nxt = VW'(sum >>> FRAC_BITS);
      CMD_TRN:  val_nxt = VW'(p2_r) + VW'(t2_r);
      CMD_ITRN: val_nxt = VW'(p2_r) - VW'(t2_r);
      default:  val_nxt = VW'(p2_r);
    endcase
    pmag = p2_r[CW-1] ? CW'(-p2_r) : CW'(p2_r);
    dmag = d2_r[CW-1] ? CW'(-d2_r) : CW'(d2_r);
  end

  always_comb begin
    for (int i = 0; i < NW; i++) begin
      sh[i]   = {rem_r[i], qn_r[i][NW-1]};
      ge[i]   = sh[i] >= {1'b0, dm_r[i]};
      nrem[i] = ge[i] ? CW'(sh[i] - {1'b0, dm_r[i]}) : sh[i][CW-1:0];
    end
  end

  always_comb begin
    qs = qneg_r[NW] ? -VW'({1'b0, qn_r[NW]}) : VW'({1'b0, qn_r[NW]});
    res_nxt.dz = 1'b0;
    if (cmd_r[NW] == CMD_ISCL) begin
      sat_v = sat_fn(qs);
      if (dz_r[NW]) begin
        res_nxt.dz = 1'b1;
        if (ppos_r[NW])      sat_v = {1'b0, 1'b0, {(CW-1){1'b1}}};
        else if (pneg_r[NW]) sat_v = {1'b0, 1'b1, {(CW-1){1'b0}}};
        else                 sat_v = '0;
      end
    end else begin
      sat_v = sat_fn(val_r[NW]);
    end
    res_nxt.q   = sat_v[CW-1:0];
    res_nxt.ovf = sat_v[CW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r <= cmd;
      u1_r   <= u;
      k1_r   <= k;
      p1_r   <= p;
      t1_r   <= t;
      d1_r   <= d;

      cmd2_r <= cmd1_r;
      for (int j = 0; j < 3; j++) prod2_r[j] <= u1_r[j] * k1_r[j];
      p2_r   <= p1_r;
      t2_r   <= t1_r;
      d2_r   <= d1_r;

      cmd_r[0]  <= cmd2_r;
      val_r[0]  <= val_nxt;
      qneg_r[0] <= p2_r[CW-1] ^ d2_r[CW-1];
      dz_r[0]   <= d2_r == '0;
      ppos_r[0] <= !p2_r[CW-1] && (p2_r != '0);
      pneg_r[0] <= p2_r[CW-1];
      dm_r[0]   <= dmag;
      rem_r[0]  <= '0;
      qn_r[0]   <= {pmag, {FRAC_BITS{1'b0}}};

      for (int i = 0; i < NW; i++) begin
        cmd_r[i+1]  <= cmd_r[i];
        val_r[i+1]  <= val_r[i];
        qneg_r[i+1] <= qneg_r[i];
        dz_r[i+1]   <= dz_r[i];
        ppos_r[i+1] <= ppos_r[i];
        pneg_r[i+1] <= pneg_r[i];
        dm_r[i+1]   <= dm_r[i];
        rem_r[i+1]  <= nrem[i];
        qn_r[i+1]   <= {qn_r[i][NW-2:0], ge[i]};
      end

      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

// ===== rtl/affine_point_transform.sv =====
// Top level: matrix registers, operand routing, three lanes and handshake.
// The divider resolves one quotient bit per stage.
// Throughput: one transaction per cycle; a stalled output with a valid result holds the whole pipeline.
// Reset: valid bits cleared, matrix registers to identity with zero translation.
`default_nettype none
module affine_point_transform import apt_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [2:0]       in_cmd,
  input  wire logic signed [IO_W-1:0] in_px,
  input  wire logic signed [IO_W-1:0] in_py,
  input  wire logic signed [IO_W-1:0] in_pz,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic signed [IO_W-1:0] out_qx,
  output logic signed [IO_W-1:0] out_qy,
  output logic signed [IO_W-1:0] out_qz,
  output logic                  out_overflow,
  output logic                  out_div_zero,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data
);

  localparam logic [CFG_W-1:0] ONE = CFG_W'(1) << FRAC_BITS;

  logic [CFG_W-1:0] mat_r [NUM_REGS];
  logic             vld_r [LAT];
  logic             en;

  coord_t    m  [3][3];
  coord_t    tv [3];
  coord_t    pt [3];
  coord_t    lu [3][3];
  coord_t    lk [3][3];
  coord_t    lp [3], lt [3], ld [3];
  lane_res_t lres [3];

  assign en        = !(vld_r[LAT-1] && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mat_r[REG_E0_E1]   <= ONE;
      mat_r[REG_E2_E4]   <= '0;
      mat_r[REG_E5_E6]   <= ONE;
      mat_r[REG_E8_E9]   <= '0;
      mat_r[REG_E10_E12] <= ONE;
      mat_r[REG_E13_E14] <= '0;
    end else if (cfg_valid && cfg_index < IDX_W'(NUM_REGS)) begin
      mat_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_comb begin
    // m[r][c]: row r, column c of the 3x3 part
    m[0][0] = mat_r[REG_E0_E1][CW-1:0];
    m[1][0] = mat_r[REG_E0_E1][32 +: CW];
    m[2][0] = mat_r[REG_E2_E4][CW-1:0];
    m[0][1] = mat_r[REG_E2_E4][32 +: CW];
    m[1][1] = mat_r[REG_E5_E6][CW-1:0];
    m[2][1] = mat_r[REG_E5_E6][32 +: CW];
    m[0][2] = mat_r[REG_E8_E9][CW-1:0];
    m[1][2] = mat_r[REG_E8_E9][32 +: CW];
    m[2][2] = mat_r[REG_E10_E12][CW-1:0];
    tv[0]   = mat_r[REG_E10_E12][32 +: CW];
    tv[1]   = mat_r[REG_E13_E14][CW-1:0];
    tv[2]   = mat_r[REG_E13_E14][32 +: CW];
    pt[0]   = in_px[CW-1:0];
    pt[1]   = in_py[CW-1:0];
    pt[2]   = in_pz[CW-1:0];
    for (int l = 0; l < 3; l++) begin
      lp[l] = pt[l];
      lt[l] = tv[l];
      ld[l] = m[l][l];
      for (int j = 0; j < 3; j++) begin
        lu[l][j] = pt[j];
        lk[l][j] = m[l][j];
        if (in_cmd == CMD_IROT) lk[l][j] = m[j][l];
        if (in_cmd == CMD_SCL) begin
          lu[l][j] = (j == 0) ? pt[l] : '0;
          lk[l][j] = (j == 0) ? m[l][l] : '0;
        end
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    apt_lane u_lane (
      .clk (clk),
      .en  (en),
      .cmd (in_cmd),
      .u   (lu[l]),
      .k   (lk[l]),
      .p   (lp[l]),
      .t   (lt[l]),
      .d   (ld[l]),
      .res (lres[l])
    );
  end

  assign out_valid    = vld_r[LAT-1];
  assign out_qx       = IO_W'(lres[0].q);
  assign out_qy       = IO_W'(lres[1].q);
  assign out_qz       = IO_W'(lres[2].q);
  assign out_overflow = lres[0].ovf | lres[1].ovf | lres[2].ovf;
  assign out_div_zero = lres[0].dz | lres[1].dz | lres[2].dz;

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> vld_r[0])
    else $error("accepted transaction not captured");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> ($stable(out_valid) && $stable(vld_r[0])))
    else $error("pipeline moved while stalled");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("valid after reset");

endmodule
`default_nettype wire
